>>> sv/hsfd_pkg.sv
package hsfd_pkg;

	localparam int unsigned PAYLOAD_LENGTH = 64;

	localparam logic [7:0] HEADER_FIRST_RST = 8'hFE;
	localparam logic [7:0] HEADER_SECOND_RST = 8'hFF;
	localparam logic [7:0] HEADER_THIRD_RST = 8'h00;

	// config register indexes
	localparam logic [1:0] REG_HEADER_FIRST = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_HEADER_THIRD = 2'd2;

	// sync states
	localparam logic [2:0] ST_WAIT1 = 3'd0;
	localparam logic [2:0] ST_WAIT2 = 3'd1;
	localparam logic [2:0] ST_WAIT3 = 3'd2;
	localparam logic [2:0] ST_COLLECT = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;

	// event codes
	localparam logic [2:0] EV_IDLE = 3'd0;
	localparam logic [2:0] EV_PAYLOAD = 3'd1;
	localparam logic [2:0] EV_GOOD = 3'd2;
	localparam logic [2:0] EV_BAD = 3'd3;
	localparam logic [2:0] EV_RESYNC = 3'd4;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] header_third;
	} hsfd_cfg_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  checksum_calculated;
		logic [15:0] frames_good;
		logic [15:0] checksum_errors;
		logic [15:0] header_resyncs;
	} hsfd_res_t;

endpackage

>>> sv/hsfd_core.sv
module hsfd_core #(
	parameter int unsigned PAYLOAD_LENGTH = hsfd_pkg::PAYLOAD_LENGTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         byte_in,
	input  hsfd_pkg::hsfd_cfg_t cfg,
	output hsfd_pkg::hsfd_res_t res
);

	logic [2:0]  state_q, state_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] good_q, good_d;
	logic [15:0] bad_q, bad_d;
	logic [15:0] resync_q, resync_d;
	logic [8:0]  pos_inc;
	logic [7:0]  calc;
	logic [7:0]  sum_add;

	assign pos_inc = {1'b0, pos_q} + 9'd1;
	assign calc = ~sum_q;
	assign sum_add = sum_q + byte_in;

	always_comb begin
		state_d = state_q;
		pos_d = pos_q;
		sum_d = sum_q;
		good_d = good_q;
		bad_d = bad_q;
		resync_d = resync_q;
		res.event_res = hsfd_pkg::EV_IDLE;
		res.payload_byte = byte_in;
		res.payload_index = 8'd0;
		res.checksum_calculated = 8'd0;
		unique case (state_q)
			hsfd_pkg::ST_WAIT1: begin
				if (byte_in == cfg.header_first)
					state_d = hsfd_pkg::ST_WAIT2;
			end
			hsfd_pkg::ST_WAIT2: begin
				if (byte_in == cfg.header_second) begin
					state_d = hsfd_pkg::ST_WAIT3;
				end else begin
					resync_d = resync_q + 16'd1;
					res.event_res = hsfd_pkg::EV_RESYNC;
					state_d = (byte_in == cfg.header_first) ? hsfd_pkg::ST_WAIT2
						: hsfd_pkg::ST_WAIT1;
				end
			end
			hsfd_pkg::ST_WAIT3: begin
				if (byte_in == cfg.header_third) begin
					state_d = hsfd_pkg::ST_COLLECT;
					pos_d = 8'd0;
					sum_d = 8'd0;
				end else begin
					resync_d = resync_q + 16'd1;
					res.event_res = hsfd_pkg::EV_RESYNC;
					state_d = (byte_in == cfg.header_first) ? hsfd_pkg::ST_WAIT2
						: hsfd_pkg::ST_WAIT1;
				end
			end
			hsfd_pkg::ST_COLLECT: begin
				res.event_res = hsfd_pkg::EV_PAYLOAD;
				res.payload_index = pos_q;
				sum_d = sum_add;
				pos_d = pos_inc[7:0];
				// 9-bit compare also catches the position wrapping to zero
				if (pos_inc >= 9'(PAYLOAD_LENGTH))
					state_d = hsfd_pkg::ST_CHECK;
			end
			default: begin
				res.checksum_calculated = calc;
				if (byte_in == calc) begin
					good_d = good_q + 16'd1;
					res.event_res = hsfd_pkg::EV_GOOD;
				end else begin
					bad_d = bad_q + 16'd1;
					res.event_res = hsfd_pkg::EV_BAD;
				end
				state_d = hsfd_pkg::ST_WAIT1;
				pos_d = 8'd0;
			end
		endcase
		res.frames_good = good_d;
		res.checksum_errors = bad_d;
		res.header_resyncs = resync_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsfd_pkg::ST_WAIT1;
			pos_q <= 8'd0;
			sum_q <= 8'd0;
			good_q <= 16'd0;
			bad_q <= 16'd0;
			resync_q <= 16'd0;
		end else if (fire) begin
			state_q <= state_d;
			pos_q <= pos_d;
			sum_q <= sum_d;
			good_q <= good_d;
			bad_q <= bad_d;
			resync_q <= resync_d;
		end
	end

endmodule

>>> sv/header_sync_frame_deframer.sv
// Input beats pass through an input register, then a result register.
// Throughput: one byte per cycle while out_stall is low; the sync state, sum and counters
// update in one pass. A stalled result leaves room for one more beat in the input register.
// Reset (arst_n low, asynchronous): hunting for the first header byte, counters and sum
// zero, header registers back to FE/FF/00, both pipeline stages empty.
module header_sync_frame_deframer #(
	parameter int unsigned PAYLOAD_LENGTH = hsfd_pkg::PAYLOAD_LENGTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [7:0]  checksum_calculated,
	output logic [15:0] frames_good,
	output logic [15:0] checksum_errors,
	output logic [15:0] header_resyncs
);

	hsfd_pkg::hsfd_cfg_t cfg_q;
	hsfd_pkg::hsfd_res_t res_c;
	hsfd_pkg::hsfd_res_t res_s2;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic       adv;
	logic       fire;
	logic       in_acc;

	assign adv = !valid_s2 || !out_stall;
	assign fire = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first <= hsfd_pkg::HEADER_FIRST_RST;
			cfg_q.header_second <= hsfd_pkg::HEADER_SECOND_RST;
			cfg_q.header_third <= hsfd_pkg::HEADER_THIRD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsfd_pkg::REG_HEADER_FIRST: cfg_q.header_first <= cfg_data;
				hsfd_pkg::REG_HEADER_SECOND: cfg_q.header_second <= cfg_data;
				hsfd_pkg::REG_HEADER_THIRD: cfg_q.header_third <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			byte_s1 <= rx_byte;
		if (fire)
			res_s2 <= res_c;
	end

	hsfd_core #(
		.PAYLOAD_LENGTH(PAYLOAD_LENGTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.byte_in(byte_s1),
		.cfg(cfg_q),
		.res(res_c)
	);

	assign out_valid = valid_s2;
	assign event_res = res_s2.event_res;
	assign payload_byte = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign checksum_calculated = res_s2.checksum_calculated;
	assign frames_good = res_s2.frames_good;
	assign checksum_errors = res_s2.checksum_errors;
	assign header_resyncs = res_s2.header_resyncs;

`ifndef NO_ASSERTIONS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res == hsfd_pkg::EV_PAYLOAD)
		|-> ({1'b0, res_s2.payload_index} < 9'(PAYLOAD_LENGTH)))
		else $error("payload index beyond frame length");

	a_good_match: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res == hsfd_pkg::EV_GOOD)
		|-> (res_s2.checksum_calculated == res_s2.payload_byte))
		else $error("good frame with checksum mismatch");

	a_bad_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res == hsfd_pkg::EV_BAD)
		|-> (res_s2.checksum_calculated != res_s2.payload_byte))
		else $error("bad frame with matching checksum");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_res != hsfd_pkg::EV_PAYLOAD)
		|-> (res_s2.payload_index == 8'd0))
		else $error("index set outside payload");
`endif

endmodule
